// ===== src/plc_pkg.sv =====
// Shared constants, codes and types of the pinned-LRU cache directory.
// Used by the channel interfaces, the slot cell and the top level.
package plc_pkg;

   // Default parameter values and the fixed limits of the parameter ranges.
   localparam int SLOTS_DEF      = 4;
   localparam int NAME_BYTES_DEF = 16;
   localparam int TYPES_DEF      = 8;
   localparam int SLOTS_MAX      = 16;

   // Field widths.
   localparam int SLOT_IDX_W = $clog2(SLOTS_MAX);
   localparam int RANK_W     = $clog2(SLOTS_MAX + 2);
   localparam int PIN_W      = 8;
   localparam int TYPE_W     = 3;
   localparam int NAME_W     = 128;
   localparam int SIZE_W     = 32;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int SEL_W      = 2;

   localparam logic [PIN_W-1:0]  PIN_MAX        = '1;
   localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 32'd8192;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INVAL = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_HIT        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FILLED     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_CACHED = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DONE       = 2'd3;

   // Update operations broadcast to the cells.
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_TOUCH = 3'd1;
   localparam logic [2:0] OP_FILL  = 3'd2;
   localparam logic [2:0] OP_DROP  = 3'd3;
   localparam logic [2:0] OP_CLOSE = 3'd4;
   localparam logic [2:0] OP_INVAL = 3'd5;

   // Lookup result handed from cell to cell during the scan.
   typedef struct packed {
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_idx;
      logic [RANK_W-1:0]     hit_rank;
      logic                  victim;
      logic [SLOT_IDX_W-1:0] victim_idx;
      logic [RANK_W-1:0]     best;
      logic                  had;
   } scan_carry_type;

   // Update command broadcast to every cell.
   typedef struct packed {
      logic [2:0]            op;
      logic [SLOT_IDX_W-1:0] idx;
      logic [RANK_W-1:0]     ref_rank;
   } apply_cmd_type;

endpackage

// ===== src/plc_ifs.sv =====
// Valid/ready channel interfaces: request, response and register write.
// Depends on plc_pkg for the field widths.
interface plc_req_if;
   import plc_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [TYPE_W-1:0]   arc_type;
   logic [63:0]         name_hi;
   logic [63:0]         name_lo;
   logic [SIZE_W-1:0]   item_size;
   logic                load_ok;
   logic [SEL_W-1:0]    slot;

   modport source (output valid, kind, arc_type, name_hi, name_lo, item_size, load_ok, slot,
                   input ready);
   modport sink   (input valid, kind, arc_type, name_hi, name_lo, item_size, load_ok, slot,
                   output ready);
endinterface

interface plc_rsp_if;
   import plc_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SEL_W-1:0]    slot_used;
   logic                evicted;

   modport source (output valid, status, slot_used, evicted, input ready);
   modport sink   (input valid, status, slot_used, evicted, output ready);
endinterface

interface plc_csr_if;
   import plc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SIZE_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== src/pinned_lru_data_cache_policy.sv =====
// Top level of the pinned-LRU cache directory: request sequencing, size limit
// register, response register and the row of slot cells.
// Depends on plc_pkg, plc_ifs and plc_cell.
//
// Sequencing: an accepted request beat is registered, the lookup token then walks the cell row
// through the register of each slot, and the update and response write follow once the token leaves
// the row and the response register is free. A new request is taken only after that, while idle.
// Reset: all slots empty with rank and pin count zero, size limit 8192; no clearing pass.
module pinned_lru_data_cache_policy #(
   parameter int SLOTS      = plc_pkg::SLOTS_DEF,
   parameter int NAME_BYTES = plc_pkg::NAME_BYTES_DEF,
   parameter int TYPES      = plc_pkg::TYPES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   plc_req_if.sink   req_bus,
   plc_rsp_if.source rsp_bus,
   plc_csr_if.sink   csr_bus
);
   import plc_pkg::*;

   localparam int   KEY_W    = NAME_BYTES * 8;
   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BUSY  = 1'b1;

   logic                  state_ff, state_in;
   logic [SIZE_W-1:0]     max_size_ff;
   logic [KIND_W-1:0]     kind_ff;
   logic [TYPE_W-1:0]     type_ff;
   logic [KEY_W-1:0]      key_ff;
   logic                  load_ok_ff;
   logic [SEL_W-1:0]      sel_ff;
   logic                  eligible_ff;
   logic                  go_ff;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [SLOT_IDX_W-1:0] used_ff;
   logic                  evicted_ff;

   logic [NAME_W-1:0]     full_name;
   logic                  req_fire;
   logic                  chain_done;
   logic                  out_free;
   logic                  apply_fire;
   logic [STATUS_W-1:0]   status_nx;
   logic [SLOT_IDX_W-1:0] used_nx;
   logic                  evicted_nx;
   apply_cmd_type         cmd_nx;
   apply_cmd_type         cmd;
   scan_carry_type        fc;

   logic           go_w    [SLOTS+1];
   scan_carry_type carry_w [SLOTS+1];

   // Size limit register; writes are to come only while idle, a rule the block itself does not enforce.
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RESET;
      end else if (csr_bus.valid) begin
         max_size_ff <= csr_bus.data;
      end
   end

   // Request capture.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign full_name     = {req_bus.name_hi, req_bus.name_lo};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff     <= req_bus.kind;
         type_ff     <= req_bus.arc_type;
         key_ff      <= full_name[NAME_W-1 -: KEY_W];
         load_ok_ff  <= req_bus.load_ok;
         sel_ff      <= req_bus.slot;
         eligible_ff <= (req_bus.item_size <= max_size_ff) &&
                        (32'(req_bus.arc_type) < 32'(TYPES));
      end
   end

   // Cell row: a lookup token enters slot 0 and walks to the last slot.
   assign go_w[0]               = go_ff;
   assign carry_w[0].hit        = 1'b0;
   assign carry_w[0].hit_idx    = '0;
   assign carry_w[0].hit_rank   = '0;
   assign carry_w[0].victim     = 1'b0;
   assign carry_w[0].victim_idx = '0;
   assign carry_w[0].best       = RANK_W'(SLOTS + 1);
   assign carry_w[0].had        = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      plc_cell #(
         .SLOTS    (SLOTS),
         .KEY_W    (KEY_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .go_in     (go_w[i]),
         .carry_in  (carry_w[i]),
         .go_out    (go_w[i+1]),
         .carry_out (carry_w[i+1]),
         .q_type    (type_ff),
         .q_key     (key_ff),
         .cmd       (cmd)
      );
   end

   assign fc         = carry_w[SLOTS];
   assign chain_done = go_w[SLOTS] || done_ff;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign apply_fire = (state_ff == ST_BUSY) && chain_done && out_free;

   // Decide the update and the response from the scan result.
   always_comb begin
      cmd_nx.op       = OP_NONE;
      cmd_nx.idx      = '0;
      cmd_nx.ref_rank = '0;
      status_nx       = STAT_DONE;
      used_nx         = '0;
      evicted_nx      = 1'b0;
      unique case (kind_ff)
         KIND_OPEN: begin
            status_nx = STAT_NOT_CACHED;
            if (eligible_ff) begin
               if (fc.hit) begin
                  cmd_nx.op       = OP_TOUCH;
                  cmd_nx.idx      = fc.hit_idx;
                  cmd_nx.ref_rank = fc.hit_rank;
                  status_nx       = STAT_HIT;
                  used_nx         = fc.hit_idx;
               end else if (fc.victim) begin
                  cmd_nx.idx = fc.victim_idx;
                  if (load_ok_ff) begin
                     cmd_nx.op  = OP_FILL;
                     status_nx  = STAT_FILLED;
                     used_nx    = fc.victim_idx;
                     evicted_nx = fc.had;
                  end else begin
                     cmd_nx.op = OP_DROP;
                  end
               end
            end
         end
         KIND_CLOSE: begin
            if (32'(sel_ff) < 32'(SLOTS)) begin
               cmd_nx.op  = OP_CLOSE;
               cmd_nx.idx = SLOT_IDX_W'(sel_ff);
            end
         end
         KIND_INVAL: begin
            if (32'(type_ff) < 32'(TYPES)) begin
               cmd_nx.op = OP_INVAL;
            end
         end
         default: begin
         end
      endcase
   end

   // The command reaches the cells only in the cycle the response is written.
   always_comb begin
      cmd = cmd_nx;
      if (!apply_fire) begin
         cmd.op = OP_NONE;
      end
   end

   // Sequencer and response register.
   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         state_in = ST_BUSY;
      end
      if (go_w[SLOTS]) begin
         done_in = 1'b1;
      end
      if (apply_fire) begin
         state_in     = ST_IDLE;
         done_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= req_fire;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (apply_fire) begin
         status_ff  <= status_nx;
         used_ff    <= used_nx;
         evicted_ff <= evicted_nx;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = status_ff;
   assign rsp_bus.slot_used = used_ff[SEL_W-1:0];
   assign rsp_bus.evicted   = evicted_ff;

   // An accepted request keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_BUSY) && !req_bus.ready)
      else $error("block idle right after a request beat");

   // A new response appears only when a request was being worked on.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_BUSY))
      else $error("response without a request");

   // Only a fill can report an eviction.
   a_evict_only_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != STAT_FILLED) |-> !evicted_ff)
      else $error("eviction reported without a fill");

   // The lookup token leaves the row only while a request is in flight.
   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      go_w[SLOTS] |-> state_ff == ST_BUSY)
      else $error("scan finished with no request in flight");

endmodule

// ===== src/plc_cell.sv =====
// One directory slot: rank, pin count and key, plus one stage of the lookup scan.
// Depends on plc_pkg for the scan carry and update command types.
module plc_cell #(
   parameter int SLOTS    = plc_pkg::SLOTS_DEF,
   parameter int KEY_W    = plc_pkg::NAME_BYTES_DEF * 8,
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go_in,
   input  plc_pkg::scan_carry_type       carry_in,
   output logic                          go_out,
   output plc_pkg::scan_carry_type       carry_out,
   input  logic [plc_pkg::TYPE_W-1:0]    q_type,
   input  logic [KEY_W-1:0]              q_key,
   input  plc_pkg::apply_cmd_type        cmd
);
   import plc_pkg::*;

   localparam logic [SLOT_IDX_W-1:0] ME       = SLOT_IDX_W'(CELL_IDX);
   localparam logic [RANK_W-1:0]     TOP_RANK = RANK_W'(SLOTS);

   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [PIN_W-1:0]  pin_ff, pin_in;
   logic              holds_ff, holds_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              go_ff;
   scan_carry_type    carry_ff, carry_in_nx;
   logic              match;
   logic              selected;

   assign selected = (cmd.idx == ME);
   assign match    = (rank_ff != '0) && (type_ff == q_type) && (key_ff == q_key);

   // Scan stage: take the hit or improve the victim choice, unless an earlier slot hit.
   always_comb begin
      carry_in_nx = carry_in;
      if (!carry_in.hit) begin
         if (match) begin
            carry_in_nx.hit      = 1'b1;
            carry_in_nx.hit_idx  = ME;
            carry_in_nx.hit_rank = rank_ff;
         end else if ((pin_ff == '0) && (rank_ff < carry_in.best)) begin
            carry_in_nx.victim     = 1'b1;
            carry_in_nx.victim_idx = ME;
            carry_in_nx.best       = rank_ff;
            carry_in_nx.had        = holds_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= go_in;
      end
      if (go_in) begin
         carry_ff <= carry_in_nx;
      end
   end

   assign go_out    = go_ff;
   assign carry_out = carry_ff;

   // Slot update from the broadcast command.
   always_comb begin
      rank_in  = rank_ff;
      pin_in   = pin_ff;
      holds_in = holds_ff;
      type_in  = type_ff;
      key_in   = key_ff;
      case (cmd.op) inside
         OP_TOUCH, OP_FILL: begin
            if (selected) begin
               rank_in = TOP_RANK;
               if (pin_ff != PIN_MAX) begin
                  pin_in = pin_ff + PIN_W'(1);
               end
               if (cmd.op == OP_FILL) begin
                  holds_in = 1'b1;
                  type_in  = q_type;
                  key_in   = q_key;
               end
            end else if (rank_ff > cmd.ref_rank) begin
               rank_in = rank_ff - RANK_W'(1);
            end
         end
         OP_DROP: begin
            if (selected) begin
               rank_in  = '0;
               holds_in = 1'b0;
            end
         end
         OP_CLOSE: begin
            if (selected && (pin_ff != '0)) begin
               pin_in = pin_ff - PIN_W'(1);
            end
         end
         OP_INVAL: begin
            if (type_ff == q_type) begin
               rank_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff  <= '0;
         pin_ff   <= '0;
         holds_ff <= 1'b0;
      end else begin
         rank_ff  <= rank_in;
         pin_ff   <= pin_in;
         holds_ff <= holds_in;
      end
      type_ff <= type_in;
      key_ff  <= key_in;
   end

   // The rank never exceeds the slot count.
   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      rank_ff <= TOP_RANK)
      else $error("slot rank above slot count");

   // A touched or filled slot becomes most recent.
   a_touch_top: assert property (@(posedge clock) disable iff (reset)
      selected && ((cmd.op == OP_TOUCH) || (cmd.op == OP_FILL)) |=> rank_ff == TOP_RANK)
      else $error("touched slot is not most recent");

   // A release of a pinned slot lowers its pin count by one.
   a_close_dec: assert property (@(posedge clock) disable iff (reset)
      selected && (cmd.op == OP_CLOSE) && (pin_ff != '0) |=> pin_ff == $past(pin_ff) - PIN_W'(1))
      else $error("release did not lower the pin count");

endmodule

// ===== test/pinned_lru_data_cache_policy_test.sv =====
// Self-checking testbench of the pinned-LRU cache directory, with the directory predictor inside.
// Uses plc_pkg and the channel interfaces in plc_ifs, and drives pinned_lru_data_cache_policy.
// Directed and random requests run under random stalls on both channels and several size limits.
module pinned_lru_data_cache_policy_test;
   timeunit 1ns;
   timeprecision 1ps;
   import plc_pkg::*;

   localparam int NSLOTS      = SLOTS_DEF;
   localparam int NTYPES      = TYPES_DEF;
   localparam int CLK_HALF    = 6;
   localparam int LATENCY     = SLOTS_DEF + 1;
   localparam int GAP_MAX     = 17;
   localparam int KEY_COUNT   = 6;
   localparam int PHASE_ITEMS = 220;
   localparam int PRINT_CAP   = 100;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [TYPE_W-1:0] arc_type;
      logic [63:0]       name_hi;
      logic [63:0]       name_lo;
      logic [SIZE_W-1:0] item_size;
      logic              load_ok;
      logic [SEL_W-1:0]  slot;
   } dir_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEL_W-1:0]    slot_used;
      logic                evicted;
   } dir_rsp_type;

   // Directory predictor and the queue of responses it still waits for.
   class dir_scoreboard;
      bit [SIZE_W-1:0] size_limit;
      bit [2:0]        rank [NSLOTS];
      bit [PIN_W-1:0]  pins [NSLOTS];
      bit              holds [NSLOTS];
      bit [TYPE_W-1:0] stype [NSLOTS];
      bit [63:0]       shi [NSLOTS];
      bit [63:0]       slo [NSLOTS];
      dir_rsp_type     outcomes [$];
      int              errors;
      int              checked;
      int              status_seen [4];

      function new();
         size_limit = MAX_SIZE_RESET;
      endfunction

      // Make a slot most recent: younger slots age by one, and it gets one more pin unless saturated.
      function void promote(int s);
         for (int i = 0; i < NSLOTS; i++)
            if (rank[i] > rank[s]) rank[i]--;
         rank[s] = 3'(NSLOTS);
         if (pins[s] != PIN_MAX) pins[s]++;
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function void note_request(dir_req_type r);
         dir_rsp_type o;
         int          hit;
         int          victim;
         int          best;
         bit          had;
         o.status    = STAT_DONE;
         o.slot_used = '0;
         o.evicted   = 1'b0;
         case (r.kind)
            KIND_OPEN: begin
               o.status = STAT_NOT_CACHED;
               if (r.item_size <= size_limit && r.arc_type < NTYPES) begin
                  hit    = -1;
                  victim = -1;
                  best   = NSLOTS + 1;
                  // The scan stops at the first hit; only earlier slots compete as victims.
                  for (int i = 0; i < NSLOTS; i++) begin
                     if (hit < 0) begin
                        if (rank[i] != 0 && stype[i] == r.arc_type &&
                            shi[i] == r.name_hi && slo[i] == r.name_lo) begin
                           hit = i;
                        end else if (pins[i] == 0 && rank[i] < best) begin
                           best   = rank[i];
                           victim = i;
                        end
                     end
                  end
                  if (hit >= 0) begin
                     promote(hit);
                     o.status    = STAT_HIT;
                     o.slot_used = SEL_W'(hit);
                  end else if (victim >= 0) begin
                     // The victim loses its contents even when the load fails.
                     had           = holds[victim];
                     rank[victim]  = 0;
                     holds[victim] = r.load_ok;
                     if (r.load_ok) begin
                        stype[victim] = r.arc_type;
                        shi[victim]   = r.name_hi;
                        slo[victim]   = r.name_lo;
                        promote(victim);
                        o.status    = STAT_FILLED;
                        o.slot_used = SEL_W'(victim);
                        o.evicted   = had;
                     end
                  end
               end
            end
            KIND_CLOSE: begin
               if (r.slot < NSLOTS && pins[r.slot] != 0) pins[r.slot]--;
            end
            KIND_INVAL: begin
               if (r.arc_type < NTYPES)
                  for (int i = 0; i < NSLOTS; i++)
                     if (stype[i] == r.arc_type) rank[i] = 0;
            end
            default: ;
         endcase
         outcomes.push_back(o);
      endfunction

      task report(string what);
         errors++;
         if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Compare one response beat with the oldest expected response.
      task check_response(dir_rsp_type got);
         dir_rsp_type want;
         if (outcomes.size() == 0) begin
            report($sformatf("response with none expected: status %0d slot %0d evicted %0d",
                             got.status, got.slot_used, got.evicted));
            return;
         end
         want = outcomes.pop_front();
         checked++;
         status_seen[want.status]++;
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.slot_used !== want.slot_used)
            report($sformatf("slot_used %0d, expected %0d", got.slot_used, want.slot_used));
         if (got.evicted !== want.evicted)
            report($sformatf("evicted %0d, expected %0d", got.evicted, want.evicted));
      endtask

      function int pending();
         return outcomes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   plc_req_if req_bus ();
   plc_rsp_if rsp_bus ();
   plc_csr_if csr_bus ();

   pinned_lru_data_cache_policy u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   dir_scoreboard sb = new();
   int unsigned   cycles = 0;
   bit            send_burst = 1'b0;
   bit            take_burst = 1'b0;
   int            sent = 0;
   int            configs = 0;
   dir_req_type   keys [KEY_COUNT];

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding", cycles, sb.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Check every response beat.
   always @(posedge clock) begin
      dir_rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status    = rsp_bus.status;
         got.slot_used = rsp_bus.slot_used;
         got.evicted   = rsp_bus.evicted;
         sb.check_response(got);
      end
   end

   // Response side: a random stall before each beat, with stretches of none.
   initial begin
      int stall;
      int served;
      rsp_bus.ready <= 1'b0;
      served = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      stall = $urandom_range(0, GAP_MAX);
      forever begin
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         served++;
         if (served % 50 == 0) take_burst = ($urandom_range(0, 2) == 0);
         stall = take_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
   end

   // Send one request beat after a random gap and hand it to the predictor.
   task automatic send_item(input dir_req_type r);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.kind      <= r.kind;
      req_bus.arc_type  <= r.arc_type;
      req_bus.name_hi   <= r.name_hi;
      req_bus.name_lo   <= r.name_lo;
      req_bus.item_size <= r.item_size;
      req_bus.load_ok   <= r.load_ok;
      req_bus.slot      <= r.slot;
      req_bus.valid     <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
      sent++;
   endtask

   // Hold off requests until every response is back and the pipeline is quiet.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_limit(input logic [SIZE_W-1:0] value);
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.size_limit = value;
      configs++;
   endtask

   // A request of the given kind with every other field random.
   function automatic dir_req_type noise_item(input logic [KIND_W-1:0] kind);
      dir_req_type r;
      r.kind      = kind;
      r.arc_type  = TYPE_W'($urandom_range(0, NTYPES - 1));
      r.name_hi   = {$urandom, $urandom};
      r.name_lo   = {$urandom, $urandom};
      r.item_size = $urandom;
      r.load_ok   = 1'($urandom_range(0, 1));
      r.slot      = SEL_W'($urandom_range(0, NSLOTS - 1));
      return r;
   endfunction

   function automatic dir_req_type open_of(input dir_req_type key,
                                           input logic [SIZE_W-1:0] size, input bit load);
      dir_req_type r;
      r           = noise_item(KIND_OPEN);
      r.arc_type  = key.arc_type;
      r.name_hi   = key.name_hi;
      r.name_lo   = key.name_lo;
      r.item_size = size;
      r.load_ok   = load;
      return r;
   endfunction

   function automatic dir_req_type close_of(input int s);
      dir_req_type r;
      r      = noise_item(KIND_CLOSE);
      r.slot = SEL_W'(s);
      return r;
   endfunction

   function automatic dir_req_type inval_of(input logic [TYPE_W-1:0] t);
      dir_req_type r;
      r          = noise_item(KIND_INVAL);
      r.arc_type = t;
      return r;
   endfunction

   // Sizes cluster around the current limit so both sides of it are hit often.
   function automatic logic [SIZE_W-1:0] pick_size();
      logic [SIZE_W-1:0] lim;
      lim = sb.size_limit;
      case ($urandom_range(0, 9))
         0: return lim;
         1: return (lim == '1) ? lim : lim + 1;
         2: return $urandom;
         3: return '0;
         default: return $urandom_range(0, (lim < 4096) ? lim : 4096);
      endcase
   endfunction

   // Keys that collide on the name with another type, or differ in a single name bit.
   task automatic new_keys();
      keys[0] = noise_item(KIND_OPEN);
      keys[1] = keys[0];
      keys[1].arc_type = keys[0].arc_type + 3'd1;
      keys[2] = keys[0];
      keys[2].name_hi = keys[0].name_hi ^ (64'd1 << $urandom_range(0, 63));
      keys[3] = keys[0];
      keys[3].name_lo = keys[0].name_lo ^ (64'd1 << $urandom_range(0, 63));
      keys[4] = noise_item(KIND_OPEN);
      keys[5] = noise_item(KIND_OPEN);
   endtask

   // Mostly opens on the key set and closes of pinned slots, some invalidates and noise.
   function automatic dir_req_type random_item();
      dir_req_type r;
      int          p;
      int          s;
      p = $urandom_range(0, 99);
      if (p < 45) begin
         if ($urandom_range(0, 9) == 0) r = noise_item(KIND_OPEN);
         else r = open_of(keys[$urandom_range(0, KEY_COUNT - 1)], '0, 1'b1);
         r.item_size = pick_size();
         r.load_ok   = ($urandom_range(0, 7) != 0);
      end else if (p < 85) begin
         r = noise_item(KIND_CLOSE);
         if ($urandom_range(0, 4) != 0) begin
            s = $urandom_range(0, NSLOTS - 1);
            for (int k = NSLOTS - 1; k >= 0; k--)
               if (sb.pins[(s + k) % NSLOTS] != 0) r.slot = SEL_W'((s + k) % NSLOTS);
         end
      end else if (p < 95) begin
         r = noise_item(KIND_INVAL);
         if ($urandom_range(0, 4) != 0)
            r.arc_type = keys[$urandom_range(0, KEY_COUNT - 1)].arc_type;
      end else begin
         r = noise_item(KIND_NOP);
      end
      return r;
   endfunction

   // Short walk through the corner cases of the directory at the reset limit.
   task automatic directed();
      dir_req_type zero_key;
      dir_req_type ones_key;
      zero_key          = noise_item(KIND_OPEN);
      zero_key.arc_type = '0;
      zero_key.name_hi  = '0;
      zero_key.name_lo  = '0;
      ones_key          = noise_item(KIND_OPEN);
      ones_key.arc_type = '1;
      ones_key.name_hi  = '1;
      ones_key.name_lo  = '1;
      // An all-zero key must not match the empty slots.
      send_item(open_of(zero_key, '0, 1'b1));
      send_item(open_of(zero_key, 32'd5, 1'b1));
      // Sizes at, just over and far over the limit.
      send_item(open_of(ones_key, MAX_SIZE_RESET, 1'b1));
      send_item(open_of(keys[1], MAX_SIZE_RESET + 1, 1'b1));
      send_item(open_of(keys[1], '1, 1'b1));
      // A failed load, then fills until every slot is pinned.
      send_item(open_of(keys[2], 32'd64, 1'b0));
      send_item(open_of(keys[2], 32'd64, 1'b1));
      send_item(open_of(keys[3], 32'd64, 1'b1));
      send_item(open_of(keys[4], 32'd64, 1'b1));
      // Unpin the first slot past zero, then evict it.
      repeat (3) send_item(close_of(0));
      send_item(open_of(keys[4], 32'd64, 1'b1));
      // Invalidate a type, reopen after unpinning, fail a load over live data.
      send_item(inval_of(ones_key.arc_type));
      send_item(open_of(ones_key, 32'd1, 1'b1));
      send_item(close_of(1));
      send_item(open_of(ones_key, 32'd1, 1'b1));
      send_item(close_of(1));
      send_item(open_of(keys[5], 32'd2, 1'b0));
      send_item(noise_item(KIND_NOP));
      for (int s = 0; s < NSLOTS; s++) send_item(close_of(s));
      send_item(inval_of(keys[5].arc_type + 3'd2));
   endtask

   // Drive one pin count to saturation and back down past zero.
   task automatic pin_saturation();
      int s;
      for (int i = 0; i < NSLOTS; i++)
         while (sb.pins[i] != 0) send_item(close_of(i));
      send_burst = 1'b1;
      repeat (int'(PIN_MAX) + 4) send_item(open_of(keys[0], 32'd1, 1'b1));
      s = 0;
      for (int i = 0; i < NSLOTS; i++)
         if (sb.rank[i] == NSLOTS) s = i;
      while (sb.pins[s] != 0) send_item(close_of(s));
      send_item(close_of(s));
      send_burst = 1'b0;
   endtask

   // Main sequence.
   initial begin
      logic [SIZE_W-1:0] limits [5];
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= KIND_OPEN;
      req_bus.arc_type  <= '0;
      req_bus.name_hi   <= '0;
      req_bus.name_lo   <= '0;
      req_bus.item_size <= '0;
      req_bus.load_ok   <= 1'b0;
      req_bus.slot      <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.data      <= '0;
      limits[0] = '0;
      limits[1] = '1;
      limits[2] = $urandom;
      limits[3] = 32'd1024;
      limits[4] = MAX_SIZE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      new_keys();
      directed();
      pin_saturation();
      drain();

      // Random phases, one per size limit, with a full pause halfway through each.
      foreach (limits[ph]) begin
         write_limit(limits[ph]);
         new_keys();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) send_burst = ($urandom_range(0, 2) == 0);
            if (n == PHASE_ITEMS / 2) drain();
            send_item(random_item());
         end
         drain();
      end

      $display("Covered %0d requests, %0d limits: %0d hits, %0d fills, %0d not cached, %0d other.",
               sent, configs, sb.status_seen[STAT_HIT], sb.status_seen[STAT_FILLED],
               sb.status_seen[STAT_NOT_CACHED], sb.status_seen[STAT_DONE]);
      $display("Checked %0d responses, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== pinned_lru_data_cache_policy.f =====
src/plc_pkg.sv
src/plc_ifs.sv
src/plc_cell.sv
src/pinned_lru_data_cache_policy.sv
test/pinned_lru_data_cache_policy_test.sv
